@@ hdl/dhsp_pkg.sv @@
// shared types and codes of the diff hunk stream parser
// result item struct, output kind codes, fault codes and character constants
package dhsp_pkg;

	localparam int unsigned LINE_BITS_DEF = 32;
	localparam int unsigned OUT_LINE_W = 32;

	localparam logic [2:0] KIND_DATA = 3'd0;
	localparam logic [2:0] KIND_HEADER = 3'd1;
	localparam logic [2:0] KIND_END_SECTION = 3'd2;
	localparam logic [2:0] KIND_END_HUNK = 3'd3;
	localparam logic [2:0] KIND_ERROR = 3'd4;

	localparam logic [1:0] HK_APPEND = 2'd0;
	localparam logic [1:0] HK_DELETE = 2'd1;
	localparam logic [1:0] HK_CHANGE = 2'd2;

	localparam logic [4:0] FAULT_NONE = 5'd0;
	localparam logic [4:0] FAULT_NO_LEAD_DIGIT = 5'd1;
	localparam logic [4:0] FAULT_DIGIT_EXPECTED = 5'd2;
	localparam logic [4:0] FAULT_RANGE_ORDER = 5'd3;
	localparam logic [4:0] FAULT_APPEND_OLD_RANGE = 5'd4;
	localparam logic [4:0] FAULT_DELETE_LINE_ZERO = 5'd5;
	localparam logic [4:0] FAULT_BAD_COMMAND = 5'd6;
	localparam logic [4:0] FAULT_APPEND_LINE_ZERO = 5'd7;
	localparam logic [4:0] FAULT_HEADER_END = 5'd8;
	localparam logic [4:0] FAULT_DELETE_NEW_RANGE = 5'd9;
	localparam logic [4:0] FAULT_WRONG_MARKER = 5'd10;
	localparam logic [4:0] FAULT_NO_SPACE = 5'd11;
	localparam logic [4:0] FAULT_SEPARATOR = 5'd12;
	localparam logic [4:0] FAULT_BAD_LINE_START = 5'd13;
	localparam logic [4:0] FAULT_NO_ADDITIONS = 5'd14;
	localparam logic [4:0] FAULT_TRUNCATED = 5'd15;
	localparam logic [4:0] FAULT_OVERFLOW = 5'd16;

	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_C = 8'h63;
	localparam logic [7:0] CH_LT = 8'h3c;
	localparam logic [7:0] CH_GT = 8'h3e;
	localparam logic [7:0] CH_DASH = 8'h2d;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_NL = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data_byte;
		logic [1:0] hunk_kind;
		logic [OUT_LINE_W-1:0] first_old_line;
		logic [OUT_LINE_W-1:0] last_old_line;
		logic [OUT_LINE_W-1:0] first_new_line;
		logic [OUT_LINE_W-1:0] last_new_line;
		logic [31:0] hunk_number;
		logic [4:0] fault_code;
		logic in_additions;
	} res_t;

endpackage

@@ hdl/dhsp_accum.sv @@
// decimal accumulate step: value times ten plus one digit, saturating
// depends on nothing but its parameter
module dhsp_accum #(
	parameter int unsigned LINE_BITS = 32
) (
	input  logic [LINE_BITS-1:0] acc,
	input  logic [3:0]           digit,
	output logic [LINE_BITS-1:0] sum,
	output logic                 ovf
);

	logic [LINE_BITS+3:0] wide;

	assign wide = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{LINE_BITS{1'b0}}, digit};
	assign ovf = |wide[LINE_BITS+3:LINE_BITS];
	assign sum = ovf ? {LINE_BITS{1'b1}} : wide[LINE_BITS-1:0];

endmodule

@@ hdl/dhsp_step.sv @@
// parser state and per-item next-state logic, one item per enabled cycle
// depends on dhsp_pkg and dhsp_accum
module dhsp_step #(
	parameter int unsigned LINE_BITS = dhsp_pkg::LINE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [7:0]      byte_in,
	input  logic            eoi,
	output logic            res_valid,
	output dhsp_pkg::res_t  res
);
	import dhsp_pkg::*;

	typedef enum logic [3:0] {
		PH_START, PH_OLD1, PH_OLD2, PH_NEW1, PH_NEW2, PH_LSTART, PH_MARK,
		PH_CONTENT, PH_DASH1, PH_DASH2, PH_DASH3, PH_SKIP, PH_SKIPNL, PH_DONE
	} phase_t;

	phase_t phase_q, phase_n;
	logic [LINE_BITS-1:0] acc_q, acc_n, of_q, of_n, ol_q, ol_n, nf_q, nf_n, nl_q, nl_n;
	logic [1:0] ck_q, ck_n;
	logic sec_q, sec_n, saw_q, saw_n;
	logic [31:0] hc_q, hc_n;

	logic is_dig;
	logic [3:0] dig;
	logic [LINE_BITS-1:0] acc_sum;
	logic acc_ovf;
	logic fail;
	logic [4:0] code;
	logic [7:0] expect_mark;

	assign is_dig = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
	assign dig = is_dig ? byte_in[3:0] : 4'd0;

	dhsp_accum #(.LINE_BITS(LINE_BITS)) u_accum (
		.acc  (acc_q),
		.digit(dig),
		.sum  (acc_sum),
		.ovf  (acc_ovf)
	);

	always_comb begin
		phase_n = phase_q;
		acc_n = acc_q;
		of_n = of_q;
		ol_n = ol_q;
		nf_n = nf_q;
		nl_n = nl_q;
		ck_n = ck_q;
		sec_n = sec_q;
		saw_n = saw_q;
		hc_n = hc_q;
		fail = 1'b0;
		code = FAULT_NONE;
		res_valid = 1'b0;
		res = '0;
		expect_mark = CH_LT;
		if (ck_q == HK_APPEND) begin
			expect_mark = CH_GT;
		end else if (ck_q == HK_CHANGE && sec_q) begin
			expect_mark = CH_GT;
		end

		if (phase_q == PH_DONE) begin
			phase_n = PH_DONE;
		end else if (eoi) begin
			if (phase_q == PH_LSTART) begin
				if (ck_q == HK_CHANGE && !sec_q) begin
					fail = 1'b1;
					code = FAULT_NO_ADDITIONS;
				end else begin
					res_valid = 1'b1;
					res.kind = KIND_END_HUNK;
				end
			end else if (phase_q != PH_START && phase_q != PH_SKIP &&
					phase_q != PH_SKIPNL) begin
				fail = 1'b1;
				code = FAULT_TRUNCATED;
			end
		end else begin
			unique case (phase_q)
				PH_START: begin
					if (!is_dig) begin
						fail = 1'b1;
						code = FAULT_NO_LEAD_DIGIT;
					end else begin
						phase_n = PH_OLD1;
						acc_n = LINE_BITS'(dig);
						saw_n = 1'b1;
					end
				end
				PH_OLD1, PH_OLD2, PH_NEW1, PH_NEW2: begin
					if (is_dig) begin
						acc_n = acc_sum;
						if (acc_ovf) begin
							fail = 1'b1;
							code = FAULT_OVERFLOW;
						end else begin
							saw_n = 1'b1;
						end
					end else if (phase_q == PH_OLD1 && byte_in == CH_COMMA) begin
						of_n = acc_q;
						acc_n = '0;
						saw_n = 1'b0;
						phase_n = PH_OLD2;
					end else if (phase_q != PH_OLD1 && !saw_q) begin
						fail = 1'b1;
						code = FAULT_DIGIT_EXPECTED;
					end else if (phase_q == PH_OLD1 || phase_q == PH_OLD2) begin
						if (phase_q == PH_OLD1) begin
							of_n = acc_q;
						end
						ol_n = acc_q;
						if (phase_q == PH_OLD2 && acc_q < of_q) begin
							fail = 1'b1;
							code = FAULT_RANGE_ORDER;
						end else if (byte_in == CH_A) begin
							if (ol_n != of_n) begin
								fail = 1'b1;
								code = FAULT_APPEND_OLD_RANGE;
							end else begin
								ck_n = HK_APPEND;
							end
						end else if (byte_in == CH_D) begin
							if (of_n == '0) begin
								fail = 1'b1;
								code = FAULT_DELETE_LINE_ZERO;
							end else begin
								ck_n = HK_DELETE;
							end
						end else if (byte_in == CH_C) begin
							ck_n = HK_CHANGE;
						end else begin
							fail = 1'b1;
							code = FAULT_BAD_COMMAND;
						end
						if (!fail) begin
							phase_n = PH_NEW1;
							acc_n = '0;
							saw_n = 1'b0;
						end
					end else begin
						if (phase_q == PH_NEW2) begin
							nl_n = acc_q;
						end
						if (ck_q == HK_APPEND && acc_q == '0) begin
							fail = 1'b1;
							code = FAULT_APPEND_LINE_ZERO;
						end else if (phase_q == PH_NEW1 && byte_in == CH_COMMA) begin
							nf_n = acc_q;
							acc_n = '0;
							saw_n = 1'b0;
							phase_n = PH_NEW2;
						end else if (phase_q == PH_NEW2 && acc_q < nf_q) begin
							fail = 1'b1;
							code = FAULT_RANGE_ORDER;
						end else if (byte_in != CH_NL) begin
							fail = 1'b1;
							code = FAULT_HEADER_END;
						end else if (phase_q == PH_NEW2 && ck_q == HK_DELETE &&
								acc_q != nf_q) begin
							fail = 1'b1;
							code = FAULT_DELETE_NEW_RANGE;
						end else begin
							if (phase_q == PH_NEW1) begin
								nf_n = acc_q;
								nl_n = acc_q;
							end
							if (hc_q != 32'hffff_ffff) begin
								hc_n = hc_q + 32'd1;
							end
							phase_n = PH_LSTART;
							sec_n = 1'b0;
							res_valid = 1'b1;
							res.kind = KIND_HEADER;
							res.hunk_kind = ck_q;
							res.first_old_line = OUT_LINE_W'(of_q);
							res.last_old_line = OUT_LINE_W'(ol_q);
							res.first_new_line = OUT_LINE_W'(nf_n);
							res.last_new_line = OUT_LINE_W'(nl_n);
							res.hunk_number = hc_n;
						end
					end
				end
				PH_LSTART: begin
					if (byte_in == CH_LT || byte_in == CH_GT) begin
						if (byte_in != expect_mark) begin
							fail = 1'b1;
							code = FAULT_WRONG_MARKER;
						end else begin
							phase_n = PH_MARK;
						end
					end else if (byte_in == CH_DASH) begin
						phase_n = PH_DASH1;
					end else if (is_dig) begin
						res_valid = 1'b1;
						if (ck_q == HK_CHANGE && !sec_q) begin
							res.kind = KIND_ERROR;
							res.fault_code = FAULT_NO_ADDITIONS;
						end else begin
							res.kind = KIND_END_HUNK;
						end
						phase_n = PH_OLD1;
						acc_n = LINE_BITS'(dig);
						saw_n = 1'b1;
					end else begin
						fail = 1'b1;
						code = FAULT_BAD_LINE_START;
					end
				end
				PH_MARK: begin
					if (byte_in != CH_SPACE) begin
						fail = 1'b1;
						code = FAULT_NO_SPACE;
					end else begin
						phase_n = PH_CONTENT;
					end
				end
				PH_CONTENT: begin
					res_valid = 1'b1;
					res.kind = KIND_DATA;
					res.data_byte = byte_in;
					res.in_additions = (ck_q == HK_APPEND) || (ck_q == HK_CHANGE && sec_q);
					if (byte_in == CH_NL) begin
						phase_n = PH_LSTART;
					end
				end
				PH_DASH1, PH_DASH2: begin
					if (byte_in != CH_DASH) begin
						fail = 1'b1;
						code = FAULT_SEPARATOR;
					end else begin
						phase_n = (phase_q == PH_DASH1) ? PH_DASH2 : PH_DASH3;
					end
				end
				PH_DASH3: begin
					if (byte_in != CH_NL || ck_q != HK_CHANGE || sec_q) begin
						fail = 1'b1;
						code = FAULT_SEPARATOR;
					end else begin
						sec_n = 1'b1;
						phase_n = PH_LSTART;
						res_valid = 1'b1;
						res.kind = KIND_END_SECTION;
					end
				end
				PH_SKIP: begin
					if (byte_in == CH_NL) begin
						phase_n = PH_SKIPNL;
					end
				end
				PH_SKIPNL: begin
					if (is_dig) begin
						phase_n = PH_OLD1;
						acc_n = LINE_BITS'(dig);
						saw_n = 1'b1;
					end else if (byte_in != CH_NL) begin
						phase_n = PH_SKIP;
					end
				end
				default: begin
					phase_n = PH_DONE;
				end
			endcase
		end

		if (fail) begin
			res_valid = 1'b1;
			res = '0;
			res.kind = KIND_ERROR;
			res.fault_code = code;
			phase_n = (!eoi && byte_in == CH_NL) ? PH_SKIPNL : PH_SKIP;
		end
		if (eoi) begin
			phase_n = PH_DONE;
		end
		if (!en) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			acc_q <= '0;
			of_q <= '0;
			ol_q <= '0;
			nf_q <= '0;
			nl_q <= '0;
			ck_q <= HK_APPEND;
			sec_q <= 1'b0;
			saw_q <= 1'b0;
			hc_q <= '0;
		end else if (en) begin
			phase_q <= phase_n;
			acc_q <= acc_n;
			of_q <= of_n;
			ol_q <= ol_n;
			nf_q <= nf_n;
			nl_q <= nl_n;
			ck_q <= ck_n;
			sec_q <= sec_n;
			saw_q <= saw_n;
			hc_q <= hc_n;
		end
	end

endmodule

@@ hdl/diff_hunk_stream_parser.sv @@
// normal-format diff hunk parser, top level with input and result registers
// depends on dhsp_pkg and dhsp_step
// the input register feeds the parser step, which loads the result register
// throughput: one byte/cycle unless stalled, set by the single parser state update
// a stalled result register holds the input register, which then holds in_ready low
// reset: asynchronous, clears parser state, hunk count and both valid flags
module diff_hunk_stream_parser #(
	parameter int unsigned LINE_BITS = dhsp_pkg::LINE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_in,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  data_byte,
	output logic [1:0]  hunk_kind,
	output logic [31:0] first_old_line,
	output logic [31:0] last_old_line,
	output logic [31:0] first_new_line,
	output logic [31:0] last_new_line,
	output logic [31:0] hunk_number,
	output logic [4:0]  fault_code,
	output logic        in_additions
);
	import dhsp_pkg::*;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic eoi_s1;
	logic advance;
	logic step_valid;
	res_t step_res;
	logic out_valid_q;
	res_t res_q;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= byte_in;
			eoi_s1 <= end_of_input;
		end
	end

	dhsp_step #(.LINE_BITS(LINE_BITS)) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.byte_in  (byte_s1),
		.eoi      (eoi_s1),
		.res_valid(step_valid),
		.res      (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && step_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_valid) begin
			res_q <= step_res;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = res_q.kind;
	assign data_byte = res_q.data_byte;
	assign hunk_kind = res_q.hunk_kind;
	assign first_old_line = res_q.first_old_line;
	assign last_old_line = res_q.last_old_line;
	assign first_new_line = res_q.first_new_line;
	assign last_new_line = res_q.last_new_line;
	assign hunk_number = res_q.hunk_number;
	assign fault_code = res_q.fault_code;
	assign in_additions = res_q.in_additions;

endmodule

@@ tb/diff_hunk_stream_parser_test.sv @@
`timescale 1ns / 100ps
// testbench of diff_hunk_stream_parser: directed and random diff streams
// with a byte-level parser prediction; depends on dhsp_pkg and the block's rtl
module diff_hunk_stream_parser_test;
	import dhsp_pkg::*;

	typedef enum logic [3:0] {
		P_START, P_OLD1, P_OLD2, P_NEW1, P_NEW2, P_LSTART, P_MARK, P_CONTENT,
		P_DASH1, P_DASH2, P_DASH3, P_SKIP, P_SKIPNL, P_DONE
	} parse_phase_t;

	localparam int RANDOM_ITEMS = 1150;
	localparam int SINK_HOLD_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  byte_in;
	logic        end_of_input;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  kind;
	logic [7:0]  data_byte;
	logic [1:0]  hunk_kind;
	logic [31:0] first_old_line;
	logic [31:0] last_old_line;
	logic [31:0] first_new_line;
	logic [31:0] last_new_line;
	logic [31:0] hunk_number;
	logic [4:0]  fault_code;
	logic        in_additions;

	parse_phase_t fsm_phase;
	logic [31:0]  num_acc;
	logic [31:0]  old_lo, old_hi, new_lo, new_hi;
	logic [1:0]   cur_hunk_kind;
	logic         in_second_section;
	logic [31:0]  hunks_seen;
	logic         digits_seen;

	res_t       parse_results_due[$];
	logic [7:0] stream_bytes[$];
	int         mismatches;
	int         sent_items;
	int         sink_hold;
	bit         src_gaps;
	bit         sink_gaps;

	diff_hunk_stream_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_in(byte_in),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.hunk_kind(hunk_kind),
		.first_old_line(first_old_line),
		.last_old_line(last_old_line),
		.first_new_line(first_new_line),
		.last_new_line(last_new_line),
		.hunk_number(hunk_number),
		.fault_code(fault_code),
		.in_additions(in_additions)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic res_t fault_result(logic [4:0] code, logic [7:0] b);
		res_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.fault_code = code;
		fsm_phase = (b == CH_NL) ? P_SKIPNL : P_SKIP;
		return r;
	endfunction

	function automatic void start_header(logic [3:0] d);
		fsm_phase = P_OLD1;
		num_acc = {28'd0, d};
		digits_seen = 1'b1;
	endfunction

	function automatic bit push_digit(logic [3:0] d, logic [7:0] b, output res_t r);
		logic [63:0] v;
		r = '0;
		v = {32'd0, num_acc} * 64'd10 + {60'd0, d};
		if (v > 64'hFFFF_FFFF) begin
			num_acc = 32'hFFFF_FFFF;
			r = fault_result(FAULT_OVERFLOW, b);
			return 1'b1;
		end
		num_acc = v[31:0];
		digits_seen = 1'b1;
		return 1'b0;
	endfunction

	function automatic bit take_command(logic [7:0] b, output res_t r);
		r = '0;
		if (b == CH_A) begin
			if (old_hi != old_lo) begin
				r = fault_result(FAULT_APPEND_OLD_RANGE, b);
				return 1'b1;
			end
			cur_hunk_kind = HK_APPEND;
		end else if (b == CH_D) begin
			if (old_lo == 0) begin
				r = fault_result(FAULT_DELETE_LINE_ZERO, b);
				return 1'b1;
			end
			cur_hunk_kind = HK_DELETE;
		end else if (b == CH_C) begin
			cur_hunk_kind = HK_CHANGE;
		end else begin
			r = fault_result(FAULT_BAD_COMMAND, b);
			return 1'b1;
		end
		fsm_phase = P_NEW1;
		num_acc = '0;
		digits_seen = 1'b0;
		return 1'b0;
	endfunction

	function automatic res_t header_result();
		res_t r;
		r = '0;
		if (hunks_seen != 32'hFFFF_FFFF)
			hunks_seen++;
		fsm_phase = P_LSTART;
		in_second_section = 1'b0;
		r.kind = KIND_HEADER;
		r.hunk_kind = cur_hunk_kind;
		r.first_old_line = old_lo;
		r.last_old_line = old_hi;
		r.first_new_line = new_lo;
		r.last_new_line = new_hi;
		r.hunk_number = hunks_seen;
		return r;
	endfunction

	function automatic res_t hunk_end_result(logic [7:0] b);
		res_t r;
		r = '0;
		if (cur_hunk_kind == HK_CHANGE && !in_second_section)
			return fault_result(FAULT_NO_ADDITIONS, b);
		r.kind = KIND_END_HUNK;
		return r;
	endfunction

	function automatic bit parse_byte(logic [7:0] b, logic eoi, output res_t r);
		bit isdig;
		logic [3:0] d;
		logic [7:0] mark;
		r = '0;
		isdig = (b >= CH_ZERO && b <= CH_NINE);
		d = isdig ? 4'(b - CH_ZERO) : 4'd0;
		if (fsm_phase == P_DONE)
			return 1'b0;
		if (eoi) begin
			if (fsm_phase inside {P_START, P_SKIP, P_SKIPNL}) begin
				fsm_phase = P_DONE;
				return 1'b0;
			end
			if (fsm_phase == P_LSTART)
				r = hunk_end_result(8'h00);
			else
				r = fault_result(FAULT_TRUNCATED, 8'h00);
			fsm_phase = P_DONE;
			return 1'b1;
		end
		case (fsm_phase)
			P_START: begin
				if (!isdig) begin
					r = fault_result(FAULT_NO_LEAD_DIGIT, b);
					return 1'b1;
				end
				start_header(d);
				return 1'b0;
			end
			P_OLD1: begin
				if (isdig)
					return push_digit(d, b, r);
				if (b == CH_COMMA) begin
					old_lo = num_acc;
					num_acc = '0;
					digits_seen = 1'b0;
					fsm_phase = P_OLD2;
					return 1'b0;
				end
				old_lo = num_acc;
				old_hi = num_acc;
				return take_command(b, r);
			end
			P_OLD2: begin
				if (isdig)
					return push_digit(d, b, r);
				if (!digits_seen) begin
					r = fault_result(FAULT_DIGIT_EXPECTED, b);
					return 1'b1;
				end
				old_hi = num_acc;
				if (old_hi < old_lo) begin
					r = fault_result(FAULT_RANGE_ORDER, b);
					return 1'b1;
				end
				return take_command(b, r);
			end
			P_NEW1: begin
				if (isdig)
					return push_digit(d, b, r);
				if (!digits_seen) begin
					r = fault_result(FAULT_DIGIT_EXPECTED, b);
					return 1'b1;
				end
				if (cur_hunk_kind == HK_APPEND && num_acc == 0) begin
					r = fault_result(FAULT_APPEND_LINE_ZERO, b);
					return 1'b1;
				end
				if (b == CH_COMMA) begin
					new_lo = num_acc;
					num_acc = '0;
					digits_seen = 1'b0;
					fsm_phase = P_NEW2;
					return 1'b0;
				end
				if (b != CH_NL) begin
					r = fault_result(FAULT_HEADER_END, b);
					return 1'b1;
				end
				new_lo = num_acc;
				new_hi = num_acc;
				r = header_result();
				return 1'b1;
			end
			P_NEW2: begin
				if (isdig)
					return push_digit(d, b, r);
				if (!digits_seen) begin
					r = fault_result(FAULT_DIGIT_EXPECTED, b);
					return 1'b1;
				end
				new_hi = num_acc;
				if (cur_hunk_kind == HK_APPEND && new_hi == 0)
					r = fault_result(FAULT_APPEND_LINE_ZERO, b);
				else if (new_hi < new_lo)
					r = fault_result(FAULT_RANGE_ORDER, b);
				else if (b != CH_NL)
					r = fault_result(FAULT_HEADER_END, b);
				else if (cur_hunk_kind == HK_DELETE && new_hi != new_lo)
					r = fault_result(FAULT_DELETE_NEW_RANGE, b);
				else
					r = header_result();
				return 1'b1;
			end
			P_LSTART: begin
				if (b == CH_LT || b == CH_GT) begin
					if (cur_hunk_kind == HK_APPEND)
						mark = CH_GT;
					else if (cur_hunk_kind == HK_DELETE)
						mark = CH_LT;
					else
						mark = in_second_section ? CH_GT : CH_LT;
					if (b != mark) begin
						r = fault_result(FAULT_WRONG_MARKER, b);
						return 1'b1;
					end
					fsm_phase = P_MARK;
					return 1'b0;
				end
				if (b == CH_DASH) begin
					fsm_phase = P_DASH1;
					return 1'b0;
				end
				if (isdig) begin
					r = hunk_end_result(b);
					start_header(d);
					return 1'b1;
				end
				r = fault_result(FAULT_BAD_LINE_START, b);
				return 1'b1;
			end
			P_MARK: begin
				if (b != CH_SPACE) begin
					r = fault_result(FAULT_NO_SPACE, b);
					return 1'b1;
				end
				fsm_phase = P_CONTENT;
				return 1'b0;
			end
			P_CONTENT: begin
				r.kind = KIND_DATA;
				r.data_byte = b;
				if (cur_hunk_kind == HK_APPEND)
					r.in_additions = 1'b1;
				else if (cur_hunk_kind == HK_CHANGE)
					r.in_additions = in_second_section;
				if (b == CH_NL)
					fsm_phase = P_LSTART;
				return 1'b1;
			end
			P_DASH1, P_DASH2: begin
				if (b != CH_DASH) begin
					r = fault_result(FAULT_SEPARATOR, b);
					return 1'b1;
				end
				fsm_phase = (fsm_phase == P_DASH1) ? P_DASH2 : P_DASH3;
				return 1'b0;
			end
			P_DASH3: begin
				if (b != CH_NL || cur_hunk_kind != HK_CHANGE || in_second_section) begin
					r = fault_result(FAULT_SEPARATOR, b);
					return 1'b1;
				end
				in_second_section = 1'b1;
				fsm_phase = P_LSTART;
				r.kind = KIND_END_SECTION;
				return 1'b1;
			end
			P_SKIP: begin
				if (b == CH_NL)
					fsm_phase = P_SKIPNL;
				return 1'b0;
			end
			P_SKIPNL: begin
				if (isdig)
					start_header(d);
				else if (b != CH_NL)
					fsm_phase = P_SKIP;
				return 1'b0;
			end
			default: begin
				fsm_phase = P_DONE;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic send_item(logic [7:0] b, logic eoi);
		int gap;
		res_t r;
		gap = src_gaps ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in <= b;
		end_of_input <= eoi;
		do @(posedge clk); while (!in_ready);
		sent_items++;
		if (parse_byte(b, eoi, r))
			parse_results_due.push_back(r);
	endtask

	function automatic void queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			stream_bytes.push_back(s[i]);
	endfunction

	task automatic send_stream();
		while (stream_bytes.size() != 0)
			send_item(stream_bytes.pop_front(), 1'b0);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (parse_results_due.size() != 0);
	endtask

	function automatic longint unsigned pick_line_number();
		case ($urandom_range(0, 39))
			0: return 64'd0;
			1: return 64'hFFFF_FFFF;
			2: return {32'd0, $urandom};
			3: return 64'h1_0000_0000 + 64'($urandom_range(0, 999));
			default: return 64'($urandom_range(1, 60));
		endcase
	endfunction

	function automatic longint unsigned pick_range_end(longint unsigned lo);
		if ($urandom_range(0, 19) == 0 && lo != 0)
			return lo - 1;
		return lo + 64'($urandom_range(0, 4));
	endfunction

	function automatic void queue_range(longint unsigned lo, longint unsigned hi);
		if (lo == hi && $urandom_range(0, 1) == 1)
			queue_text($sformatf("%0d", lo));
		else
			queue_text($sformatf("%0d,%0d", lo, hi));
	endfunction

	function automatic void queue_data_line(logic [7:0] marker);
		int len;
		logic [7:0] b;
		stream_bytes.push_back(marker);
		stream_bytes.push_back(CH_SPACE);
		len = $urandom_range(0, 6);
		repeat (len) begin
			if ($urandom_range(0, 1) == 1)
				b = 8'($urandom_range(32, 126));
			else
				b = 8'($urandom_range(0, 255));
			if (b == CH_NL)
				b = CH_SPACE;
			stream_bytes.push_back(b);
		end
		stream_bytes.push_back(CH_NL);
	endfunction

	function automatic void queue_hunk(bit corrupt);
		logic [1:0] hk;
		longint unsigned o1, o2, n1, n2;
		int first_idx;
		first_idx = stream_bytes.size();
		case ($urandom_range(0, 2))
			0: hk = HK_APPEND;
			1: hk = HK_DELETE;
			default: hk = HK_CHANGE;
		endcase
		o1 = pick_line_number();
		o2 = pick_range_end(o1);
		n1 = pick_line_number();
		n2 = pick_range_end(n1);
		if (hk == HK_APPEND && $urandom_range(0, 9) != 0)
			o2 = o1;
		if (hk == HK_DELETE && $urandom_range(0, 9) != 0)
			n2 = n1;
		queue_range(o1, o2);
		if (hk == HK_APPEND)
			stream_bytes.push_back(CH_A);
		else if (hk == HK_DELETE)
			stream_bytes.push_back(CH_D);
		else
			stream_bytes.push_back(CH_C);
		queue_range(n1, n2);
		stream_bytes.push_back(CH_NL);
		repeat ($urandom_range(1, 3))
			queue_data_line(hk == HK_APPEND ? CH_GT : CH_LT);
		if (hk == HK_CHANGE && $urandom_range(0, 11) != 0) begin
			queue_text("---\n");
			repeat ($urandom_range(1, 3))
				queue_data_line(CH_GT);
		end
		if (corrupt)
			stream_bytes[$urandom_range(first_idx, stream_bytes.size() - 1)] =
				8'($urandom_range(0, 255));
	endfunction

	task automatic test_lead_byte();
		queue_text("x\n");
		send_stream();
	endtask

	task automatic test_hunk_forms();
		queue_text("1a1\n> hi\n0a1,3\n> ");
		stream_bytes.push_back(8'h00);
		stream_bytes.push_back(8'hFF);
		stream_bytes.push_back(8'h80);
		queue_text("\n3,4d2\n< a\n< b\n5c6,7\n< o\n---\n> n\n> m\n");
		queue_text("4294967295,4294967295c4294967295,4294967295\n< \n---\n> \n");
		queue_text("9d8\n< z\n");
		send_stream();
		drain_results();
	endtask

	task automatic test_header_faults();
		queue_text("1,a\n5,3c1\n1,2a3\n0d1\n1x2\n1a0\n1c2x\n1,1d2,3\n");
		queue_text("4294967296a1\n3c\n3c4,\n2a3,1\n2a0,4\n");
		send_stream();
		drain_results();
	endtask

	task automatic test_body_faults();
		queue_text("2a3\n< x\n2a3\n>x\n2d1\n-x\n2d1\n---\n2d1\nq\n");
		queue_text("2c3\n< a\n2a3\n> b\n2c3\n< a\n---\n---\n2c3\n< a\n---\n< b\n");
		send_stream();
		drain_results();
	endtask

	task automatic test_result_stall();
		src_gaps = 1'b0;
		sink_hold = SINK_HOLD_CYCLES;
		queue_text("1a1\n> ");
		repeat (40)
			stream_bytes.push_back(8'($urandom_range(32, 126)));
		queue_text("\n");
		send_stream();
		drain_results();
		src_gaps = 1'b1;
	endtask

	task automatic test_random_hunks();
		int first_count;
		int n;
		first_count = sent_items;
		n = 0;
		while (sent_items - first_count < RANDOM_ITEMS) begin
			if (n % 6 == 0) begin
				src_gaps = ($urandom_range(0, 3) != 0);
				sink_gaps = ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 14) == 0) begin
				repeat ($urandom_range(1, 8))
					stream_bytes.push_back(8'($urandom_range(0, 255)));
				stream_bytes.push_back(CH_NL);
			end else begin
				queue_hunk($urandom_range(0, 7) == 0);
			end
			send_stream();
			n++;
		end
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
	endtask

	task automatic test_end_of_stream();
		case ($urandom_range(0, 3))
			0: queue_text("\n7a8\n> e\n");
			1: queue_text("\n7c8\n< e\n");
			2: queue_text("\n7d8\n< pa");
			default: queue_text("\nzz\n");
		endcase
		send_stream();
		send_item(8'($urandom_range(0, 255)), 1'b1);
		repeat (3)
			send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_in = '0;
		end_of_input = 1'b0;
		mismatches = 0;
		sent_items = 0;
		sink_hold = 0;
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		fsm_phase = P_START;
		num_acc = '0;
		old_lo = '0;
		old_hi = '0;
		new_lo = '0;
		new_hi = '0;
		cur_hunk_kind = HK_APPEND;
		in_second_section = 1'b0;
		hunks_seen = '0;
		digits_seen = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_lead_byte();
		test_hunk_forms();
		test_header_faults();
		test_body_faults();
		test_result_stall();
		test_random_hunks();
		test_end_of_stream();

		in_valid <= 1'b0;
		waited = 0;
		while (parse_results_due.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (parse_results_due.size() != 0) begin
			$error("%0d expected result items never arrived", parse_results_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1)
				stall = sink_gaps ? $urandom_range(0, 9) : 0;
			if (sink_hold > 0) begin
				out_ready <= 1'b0;
				sink_hold--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			mismatches++;
		end
	endfunction

	initial begin
		res_t want;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (parse_results_due.size() == 0) begin
					$error("result item with nothing expected, kind %0d", kind);
					mismatches++;
				end else begin
					want = parse_results_due.pop_front();
					check_field("kind", 32'(want.kind), 32'(kind));
					check_field("data_byte", 32'(want.data_byte), 32'(data_byte));
					check_field("hunk_kind", 32'(want.hunk_kind), 32'(hunk_kind));
					check_field("first_old_line", want.first_old_line, first_old_line);
					check_field("last_old_line", want.last_old_line, last_old_line);
					check_field("first_new_line", want.first_new_line, first_new_line);
					check_field("last_new_line", want.last_new_line, last_new_line);
					check_field("hunk_number", want.hunk_number, hunk_number);
					check_field("fault_code", 32'(want.fault_code), 32'(fault_code));
					check_field("in_additions", 32'(want.in_additions), 32'(in_additions));
				end
			end
		end
	end

	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ diff_hunk_stream_parser.f @@
hdl/dhsp_pkg.sv
hdl/dhsp_accum.sv
hdl/dhsp_step.sv
hdl/diff_hunk_stream_parser.sv
tb/diff_hunk_stream_parser_test.sv
